/* rtl/bscf_pkg.sv */
// Package for the bitmap set/clear/count/find core.
// Holds the operation codes, cell control and carry types, and word helpers.
// No dependencies.
`default_nettype none

package bscf_pkg;

	localparam int WORD_BITS    = 32;
	localparam int DEF_NUM_BITS = 256;
	localparam logic [WORD_BITS-1:0] ALL_ONES = 32'hffff_ffff;

	typedef enum logic [2:0] {
		OP_TEST    = 3'd0,
		OP_SET     = 3'd1,
		OP_CLEAR   = 3'd2,
		OP_CLR_ALL = 3'd3,
		OP_SET_ALL = 3'd4,
		OP_COUNT   = 3'd5,
		OP_FIND    = 3'd6
	} op_t;

	// broadcast from the top to every cell
	typedef struct packed {
		logic       set_one;
		logic       clr_one;
		logic       set_all;
		logic       clr_all;
		logic [2:0] word_sel;
		logic [4:0] bit_sel;
		logic [2:0] find_word;
		logic [4:0] find_bit;
	} cell_ctl_t;

	// token handed from cell to cell during a count/find sweep
	typedef struct packed {
		logic       active;
		logic       found;
		logic [7:0] pos;
	} carry_t;

	// bits of word w that lie below nbits
	function automatic logic [WORD_BITS-1:0] valid_mask(input int w, input int nbits);
		int first;
		int rem;
		first = w * WORD_BITS;
		rem   = nbits - first;
		if (first + WORD_BITS <= nbits)
			return ALL_ONES;
		else if (first >= nbits)
			return '0;
		else
			return ~(ALL_ONES << rem);
	endfunction

	function automatic logic [5:0] popcount32(input logic [31:0] v);
		logic [1:0] l1 [16];
		logic [2:0] l2 [8];
		logic [3:0] l3 [4];
		logic [4:0] l4 [2];
		for (int i = 0; i < 16; i++)
			l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
		for (int i = 0; i < 8; i++)
			l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		for (int i = 0; i < 4; i++)
			l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		for (int i = 0; i < 2; i++)
			l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		return {1'b0, l4[0]} + {1'b0, l4[1]};
	endfunction

	// position of the lowest set bit; zero for an all-zero word
	function automatic logic [4:0] lowest_set(input logic [31:0] v);
		logic [31:0] oh;
		logic [4:0]  r;
		oh = v & (~v + 32'd1);
		r  = '0;
		for (int j = 0; j < 5; j++)
			for (int k = 0; k < 32; k++)
				if (((k >> j) & 1) == 1)
					r[j] = r[j] | oh[k];
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/bitmap_set_clear_count_find_core.sv */
// Top level of the bitmap set/clear/count/find core: a chain of word cells
// with a sweep token for count and find. Depends on bscf_pkg and bscf_cell.
//
//   channel   ports                          direction   handshake
//   request   operation, index               in          start && !busy
//   result    bit_value, set_count, found,   out         done (one cycle)
//             position
//
// Test, set, clear, clear all, set all: result on the cycle after the
// request is accepted; a new request may follow every cycle.
// Count and find: the token walks the chain one cell per cycle, and busy
// stays high until the token leaves the last cell; done follows.
// Reset clears the whole map at once; no sweep is needed after reset.
// The receiver cannot stall: done marks each result for one cycle only.
`default_nettype none

module bitmap_set_clear_count_find_core
	import bscf_pkg::*;
#(
	parameter int NUM_BITS = DEF_NUM_BITS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [2:0] operation,
	input  wire logic [7:0] index,
	output logic            done,
	output logic            bit_value,
	output logic [8:0]      set_count,
	output logic            found,
	output logic [7:0]      position
);

	localparam int WORD_COUNT = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int CNT_W      = $clog2(NUM_BITS + 1);
	localparam int TEST_CELLS = (WORD_COUNT < 8) ? WORD_COUNT : 8;

	logic       busy_q;
	logic       token_q;
	logic       done_q;
	logic [7:0] req_idx_q;
	logic       req_count_q;
	logic       bit_value_q;
	logic [8:0] set_count_q;
	logic       found_q;
	logic [7:0] position_q;

	logic       accept;
	logic       in_map;
	logic       sweep;
	logic       tbit_any;
	logic       sweep_end;
	op_t        op;
	cell_ctl_t  ctl;

	carry_t           carry_w [WORD_COUNT+1];
	logic [CNT_W-1:0] cnt_w   [WORD_COUNT+1];
	logic             tbit_w  [WORD_COUNT];

	assign op        = op_t'(operation);
	assign accept    = start && !busy_q;
	assign in_map    = (32'(index) < NUM_BITS);
	assign sweep     = (op == OP_COUNT) || (op == OP_FIND);
	assign sweep_end = carry_w[WORD_COUNT].active;

	always_comb begin
		ctl           = '0;
		ctl.word_sel  = index[7:5];
		ctl.bit_sel   = index[4:0];
		ctl.find_word = req_idx_q[7:5];
		ctl.find_bit  = req_idx_q[4:0];
		if (accept) begin
			case (op)
				OP_SET:     ctl.set_one = in_map;
				OP_CLEAR:   ctl.clr_one = in_map;
				OP_CLR_ALL: ctl.clr_all = 1'b1;
				OP_SET_ALL: ctl.set_all = 1'b1;
				default:    ctl.set_one = 1'b0;
			endcase
		end
	end

	always_comb begin
		tbit_any = 1'b0;
		for (int i = 0; i < TEST_CELLS; i++)
			tbit_any = tbit_any | tbit_w[i];
	end

	assign carry_w[0] = '{active: token_q, found: 1'b0, pos: 8'd0};
	assign cnt_w[0]   = '0;

	for (genvar g = 0; g < WORD_COUNT; g++) begin : g_cell
		bscf_cell #(
			.NUM_BITS (NUM_BITS),
			.CELL_IDX (g),
			.CNT_W    (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.carry_in  (carry_w[g]),
			.cnt_in    (cnt_w[g]),
			.carry_out (carry_w[g+1]),
			.cnt_out   (cnt_w[g+1]),
			.tbit      (tbit_w[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			token_q <= 1'b0;
			done_q  <= 1'b0;
		end else if (accept) begin
			busy_q  <= sweep;
			token_q <= sweep;
			done_q  <= !sweep;
		end else begin
			token_q <= 1'b0;
			done_q  <= sweep_end;
			if (sweep_end)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_idx_q   <= index;
			req_count_q <= (op == OP_COUNT);
			bit_value_q <= (op == OP_TEST) && in_map && tbit_any;
			set_count_q <= '0;
			found_q     <= 1'b0;
			position_q  <= '0;
		end else if (sweep_end) begin
			bit_value_q <= 1'b0;
			if (req_count_q) begin
				found_q    <= 1'b0;
				position_q <= '0;
				if (32'(cnt_w[WORD_COUNT]) > 32'd511)
					set_count_q <= 9'h1ff;
				else
					set_count_q <= 9'(cnt_w[WORD_COUNT]);
			end else begin
				set_count_q <= '0;
				found_q     <= carry_w[WORD_COUNT].found;
				position_q  <= carry_w[WORD_COUNT].found ? carry_w[WORD_COUNT].pos : 8'd0;
			end
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign bit_value = bit_value_q;
	assign set_count = set_count_q;
	assign found     = found_q;
	assign position  = position_q;

	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		token_q |-> busy_q)
		else $error("sweep token without busy");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_end |-> busy_q && !token_q)
		else $error("sweep ended outside a busy period");

	a_rise_nodone: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> !done_q)
		else $error("done raised on the cycle a sweep began");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !found_q |-> position_q == 8'd0)
		else $error("position nonzero without found");

endmodule

`default_nettype wire

/* rtl/bscf_cell.sv */
// One cell of the bitmap chain: a 32-bit word of the map plus one stage of
// the count/find sweep. Depends on bscf_pkg.
`default_nettype none

module bscf_cell
	import bscf_pkg::*;
#(
	parameter int NUM_BITS = DEF_NUM_BITS,
	parameter int CELL_IDX = 0,
	parameter int CNT_W    = $clog2(NUM_BITS + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_ctl_t        ctl,
	input  wire carry_t           carry_in,
	input  wire logic [CNT_W-1:0] cnt_in,
	output carry_t                carry_out,
	output logic [CNT_W-1:0]      cnt_out,
	output logic                  tbit
);

	localparam logic [WORD_BITS-1:0] VMASK = valid_mask(CELL_IDX, NUM_BITS);
	localparam logic [7:0]           BASE  = 8'(CELL_IDX * WORD_BITS);

	logic [WORD_BITS-1:0] word_q;
	carry_t               carry_q;
	logic [CNT_W-1:0]     cnt_q;

	logic                 is_sel;
	logic                 below;
	logic                 at_start;
	logic [WORD_BITS-1:0] masked;
	carry_t               carry_d;

	assign is_sel   = (CELL_IDX == int'(ctl.word_sel));
	assign below    = (CELL_IDX < int'(ctl.find_word));
	assign at_start = (CELL_IDX == int'(ctl.find_word));
	assign tbit     = is_sel & word_q[ctl.bit_sel];

	always_comb begin
		masked = word_q & VMASK;
		if (below)
			masked = '0;
		else if (at_start)
			masked = masked & (ALL_ONES << ctl.find_bit);

		carry_d        = carry_in;
		if (!carry_in.found && (masked != '0)) begin
			carry_d.found = 1'b1;
			carry_d.pos   = BASE | {3'b000, lowest_set(masked)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q  <= '0;
			carry_q <= '0;
		end else begin
			carry_q <= carry_d;
			if (ctl.clr_all)
				word_q <= '0;
			else if (ctl.set_all)
				word_q <= VMASK;
			else if (ctl.set_one && is_sel)
				word_q <= word_q | (WORD_BITS'(1) << ctl.bit_sel);
			else if (ctl.clr_one && is_sel)
				word_q <= word_q & ~(WORD_BITS'(1) << ctl.bit_sel);
		end
	end

	// count payload, meaningful only alongside carry_q.active
	always_ff @(posedge clk) begin
		cnt_q <= cnt_in + CNT_W'(popcount32(word_q & VMASK));
	end

	assign carry_out = carry_q;
	assign cnt_out   = cnt_q;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for bitmap_set_clear_count_find_core (256-bit map).
// Holds its own bitmap model and checks every result word against it.
// Depends on bscf_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
	import bscf_pkg::*;

	localparam int MAP_BITS = DEF_NUM_BITS;
	localparam int CYCLE_LIMIT = 300000;
	localparam int MAX_PRINTS = 60;
	localparam int WALK_STEPS = 12;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	typedef struct packed {
		logic       bit_value;
		logic [8:0] set_count;
		logic       found;
		logic [7:0] position;
	} bitmap_answer_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [2:0] operation = 3'd0;
	logic [7:0] index = 8'd0;
	logic       busy;
	logic       done;
	logic       bit_value;
	logic [8:0] set_count;
	logic       found;
	logic [7:0] position;

	logic [MAP_BITS-1:0] model_bits = '0;
	bitmap_answer_t pending_answers[$];
	int mismatches = 0;
	int cycles = 0;
	int idle_pct = 0;

	bitmap_set_clear_count_find_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.index(index),
		.done(done),
		.bit_value(bit_value),
		.set_count(set_count),
		.found(found),
		.position(position)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[bitmap_set_clear_count_find_core] ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	// Updates the model map and returns the answer the core should give.
	function automatic bitmap_answer_t predict_answer(input logic [2:0] op,
			input logic [7:0] idx);
		bitmap_answer_t a;
		int total;
		a = '0;
		total = 0;
		case (op)
			OP_TEST: if (idx < MAP_BITS) a.bit_value = model_bits[idx];
			OP_SET: if (idx < MAP_BITS) model_bits[idx] = 1'b1;
			OP_CLEAR: if (idx < MAP_BITS) model_bits[idx] = 1'b0;
			OP_CLR_ALL: model_bits = '0;
			OP_SET_ALL: model_bits = '1;
			OP_COUNT: begin
				for (int i = 0; i < MAP_BITS; i++)
					total += model_bits[i];
				a.set_count = (total > 511) ? 9'd511 : total[8:0];
			end
			OP_FIND: begin
				for (int i = idx; i < MAP_BITS; i++)
					if (model_bits[i] && !a.found) begin
						a.found = 1'b1;
						a.position = i[7:0];
					end
			end
			default: ;
		endcase
		return a;
	endfunction

	// Sends one request word, with a random gap before it when idling is on.
	task automatic send_word(input logic [2:0] op, input logic [7:0] idx,
			output bitmap_answer_t ans);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		operation <= op;
		index <= idx;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		ans = predict_answer(op, idx);
		pending_answers.push_back(ans);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_answers.size() != 0);
	endtask

	always @(posedge clk) begin : check_results
		bitmap_answer_t want;
		if (arst_n && done !== 1'b0) begin
			if (pending_answers.size() == 0)
				report_mismatch("result word with nothing pending");
			else begin
				want = pending_answers.pop_front();
				if (bit_value !== want.bit_value)
					report_mismatch($sformatf("bit_value %b, want %b",
						bit_value, want.bit_value));
				if (set_count !== want.set_count)
					report_mismatch($sformatf("set_count %0d, want %0d",
						set_count, want.set_count));
				if (found !== want.found)
					report_mismatch($sformatf("found %b, want %b", found, want.found));
				if (position !== want.position)
					report_mismatch($sformatf("position %0d, want %0d",
						position, want.position));
			end
		end
	end

	task automatic test_directed();
		bitmap_answer_t ans;
		idle_pct = 0;
		send_word(OP_TEST, 8'd0, ans);
		send_word(OP_TEST, 8'd255, ans);
		send_word(OP_FIND, 8'd0, ans);      // empty map: not found
		send_word(OP_SET, 8'd0, ans);
		send_word(OP_SET, 8'd31, ans);
		send_word(OP_SET, 8'd32, ans);
		send_word(OP_SET, 8'd255, ans);
		send_word(OP_TEST, 8'd31, ans);
		send_word(OP_TEST, 8'd32, ans);
		send_word(OP_FIND, 8'd0, ans);
		send_word(OP_FIND, 8'd1, ans);
		send_word(OP_FIND, 8'd33, ans);     // crosses several empty words
		send_word(OP_FIND, 8'd255, ans);
		send_word(OP_COUNT, 8'd0, ans);
		send_word(OP_CLEAR, 8'd31, ans);
		send_word(OP_FIND, 8'd1, ans);
		send_word(OP_UNUSED, 8'd255, ans);  // no effect, all-zero answer
		send_word(OP_SET_ALL, 8'd0, ans);
		send_word(OP_COUNT, 8'd255, ans);   // full map
		send_word(OP_FIND, 8'd200, ans);
		send_word(OP_CLR_ALL, 8'd170, ans);
		send_word(OP_COUNT, 8'd85, ans);
		send_word(OP_FIND, 8'd0, ans);
		send_word(OP_TEST, 8'd255, ans);
	endtask

	// Random traffic; set_weight out of 62 splits set against clear, steering map density.
	task automatic run_mixed(input int items, input int pct, input int set_weight);
		bitmap_answer_t ans;
		logic [7:0] at;
		int sent;
		int pick;
		int steps;
		sent = 0;
		idle_pct = pct;
		while (sent < items) begin
			pick = $urandom_range(99);
			at = 8'($urandom_range(255));
			if (pick < 14) begin
				// host-style walk: next search starts just past the last hit
				if ($urandom_range(1) == 0)
					at = 8'd0;
				steps = 0;
				do begin
					send_word(OP_FIND, at, ans);
					sent++;
					steps++;
					at = ans.position + 8'd1;
				end while (ans.found && ans.position != 8'd255 && steps < WALK_STEPS);
			end else begin
				if (pick < 18)
					send_word(OP_FIND, at, ans);
				else if (pick < 26)
					send_word(OP_COUNT, at, ans);
				else if (pick < 29)
					send_word(OP_CLR_ALL, at, ans);
				else if (pick < 31)
					send_word(OP_SET_ALL, at, ans);
				else if (pick < 33)
					send_word(OP_UNUSED, at, ans);
				else if (pick < 38)
					send_word(3'($urandom_range(7)), at, ans);
				else if (pick < 53)
					send_word(OP_TEST, at, ans);
				else if ($urandom_range(61) < set_weight)
					send_word(OP_SET, at, ans);
				else
					send_word(OP_CLEAR, at, ans);
				sent++;
			end
		end
	endtask

	task automatic test_dense_back_to_back();
		run_mixed(450, 0, 42);
	endtask

	task automatic test_sparse_sender_idle();
		run_mixed(400, 79, 6);
	endtask

	task automatic test_mixed_light_idle();
		run_mixed(400, 18, 30);
	endtask

	task automatic test_sweeps_no_idle();
		run_mixed(250, 0, 20);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_dense_back_to_back();
		wait_drained();
		test_sparse_sender_idle();
		test_mixed_light_idle();
		wait_drained();
		test_sweeps_no_idle();
		wait_drained();
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("[bitmap_set_clear_count_find_core] OK");
		else
			$display("[bitmap_set_clear_count_find_core] ERROR");
		$finish;
	end

endmodule

/* files.f */
rtl/bscf_pkg.sv
rtl/bscf_cell.sv
rtl/bitmap_set_clear_count_find_core.sv
tb/testbench.sv
